FILE: sv/grs_pkg.sv
// Shared types and constants for the gimbal rate servo.
package grs_pkg;

    // item kinds on the input channel
    typedef enum logic [1:0] {
        KIND_ERROR  = 2'd0,
        KIND_STATE  = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_UPDATE = 2'd3
    } t_kind;

    // reason codes on a result
    typedef enum logic [1:0] {
        RSN_TRACK    = 2'd0,
        RSN_DISABLED = 2'd1,
        RSN_STATE    = 2'd2,
        RSN_MEAS     = 2'd3
    } t_reason;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_TRACK_EN   = 3'd0,
        REG_REQ_READY  = 3'd1,
        REG_STATE_TO   = 3'd2,
        REG_ERROR_TO   = 3'd3,
        REG_YAW_GAIN   = 3'd4,
        REG_PITCH_GAIN = 3'd5,
        REG_MAX_YAW    = 3'd6,
        REG_MAX_PITCH  = 3'd7
    } t_reg_idx;

    // shared multiplier operation
    typedef enum logic [2:0] {
        MUL_NONE     = 3'd0,
        MUL_YAW_GAIN = 3'd1,
        MUL_YAW_FACT = 3'd2,
        MUL_PIT_GAIN = 3'd3,
        MUL_PIT_FACT = 3'd4
    } t_mul_op;

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_YAW_GAIN = 3'd1,
        ST_YAW_FACT = 3'd2,
        ST_PIT_GAIN = 3'd3,
        ST_PIT_FACT = 3'd4,
        ST_PIT_DONE = 3'd5,
        ST_OUT      = 3'd6
    } t_state;

    localparam int CFG_DW    = 16;
    localparam int LIMIT_W   = 15;
    localparam int RATE_W    = 16;
    localparam int FACT_W    = 22;
    localparam int SAT_BIT   = 27;   // gain product at or above 2^27 always clamps
    localparam int ROUND_BIT = 32;   // Q12*Q12*Q16 -> Q8.8 drops 32 bits

    // degree factors, Q16
    localparam logic [FACT_W-1:0] K_RAD        = 22'd3754936; // 180/pi
    localparam logic [FACT_W-1:0] K_YAW_NORM   = 22'd1966080; // 30
    localparam logic [FACT_W-1:0] K_PITCH_NORM = 22'd1474560; // 22.5

    localparam logic [15:0] MIN_TIMEOUT = 16'd20;

    typedef struct packed {
        logic               track_en;
        logic               req_ready;
        logic [15:0]        state_to;
        logic [15:0]        error_to;
        logic [15:0]        yaw_gain;
        logic [15:0]        pitch_gain;
        logic [LIMIT_W-1:0] max_yaw;
        logic [LIMIT_W-1:0] max_pitch;
    } t_cfg;

    typedef struct packed {
        logic    store_err;
        logic    store_state;
        logic    tick;
        logic    start_upd;
        t_mul_op mul_op;
        logic    fin_yaw;
        logic    fin_pitch;
        logic    load_out;
    } t_dp_cmd;

endpackage

FILE: sv/grs_cfg.sv
// Configuration register file for the gimbal rate servo.
module grs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic [2:0]                  i_cfg_index,
    input  logic [grs_pkg::CFG_DW-1:0]  i_cfg_data,
    output logic                        o_cfg_ready,
    output grs_pkg::t_cfg               o_cfg
);

    grs_pkg::t_cfg r_cfg;
    grs_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (grs_pkg::t_reg_idx'(i_cfg_index))
                grs_pkg::REG_TRACK_EN:   n_cfg.track_en   = i_cfg_data[0];
                grs_pkg::REG_REQ_READY:  n_cfg.req_ready  = i_cfg_data[0];
                grs_pkg::REG_STATE_TO:   n_cfg.state_to   = i_cfg_data;
                grs_pkg::REG_ERROR_TO:   n_cfg.error_to   = i_cfg_data;
                grs_pkg::REG_YAW_GAIN:   n_cfg.yaw_gain   = i_cfg_data;
                grs_pkg::REG_PITCH_GAIN: n_cfg.pitch_gain = i_cfg_data;
                grs_pkg::REG_MAX_YAW:    n_cfg.max_yaw    = i_cfg_data[grs_pkg::LIMIT_W-1:0];
                grs_pkg::REG_MAX_PITCH:  n_cfg.max_pitch  = i_cfg_data[grs_pkg::LIMIT_W-1:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.track_en   <= 1'b0;
            r_cfg.req_ready  <= 1'b1;
            r_cfg.state_to   <= 16'd150;
            r_cfg.error_to   <= 16'd200;
            r_cfg.yaw_gain   <= 16'd4915;
            r_cfg.pitch_gain <= 16'd4915;
            r_cfg.max_yaw    <= 15'd7680;
            r_cfg.max_pitch  <= 15'd6400;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: sv/grs_ctrl.sv
// Sequencing state machine and output valid flag for the gimbal rate servo.
module grs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_kind,
    input  logic              i_out_stall,
    output logic              o_in_stall,
    output logic              o_out_valid,
    output grs_pkg::t_dp_cmd  o_cmd
);

    grs_pkg::t_state r_state;
    grs_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_accept;
    logic            w_slot_free;

    assign o_in_stall  = (r_state != grs_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == grs_pkg::ST_IDLE);
    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd = '0;
        o_cmd.mul_op = grs_pkg::MUL_NONE;
        case (r_state)
            grs_pkg::ST_IDLE: begin
                if (w_accept) begin
                    case (grs_pkg::t_kind'(i_kind))
                        grs_pkg::KIND_ERROR:  o_cmd.store_err   = 1'b1;
                        grs_pkg::KIND_STATE:  o_cmd.store_state = 1'b1;
                        grs_pkg::KIND_TICK:   o_cmd.tick        = 1'b1;
                        grs_pkg::KIND_UPDATE: begin
                            o_cmd.start_upd = 1'b1;
                            n_state = grs_pkg::ST_YAW_GAIN;
                        end
                        default: o_cmd.tick = 1'b0;
                    endcase
                end
            end
            grs_pkg::ST_YAW_GAIN: begin
                o_cmd.mul_op = grs_pkg::MUL_YAW_GAIN;
                n_state = grs_pkg::ST_YAW_FACT;
            end
            grs_pkg::ST_YAW_FACT: begin
                o_cmd.mul_op = grs_pkg::MUL_YAW_FACT;
                n_state = grs_pkg::ST_PIT_GAIN;
            end
            grs_pkg::ST_PIT_GAIN: begin
                o_cmd.mul_op  = grs_pkg::MUL_PIT_GAIN;
                o_cmd.fin_yaw = 1'b1;
                n_state = grs_pkg::ST_PIT_FACT;
            end
            grs_pkg::ST_PIT_FACT: begin
                o_cmd.mul_op = grs_pkg::MUL_PIT_FACT;
                n_state = grs_pkg::ST_PIT_DONE;
            end
            grs_pkg::ST_PIT_DONE: begin
                o_cmd.fin_pitch = 1'b1;
                n_state = grs_pkg::ST_OUT;
            end
            grs_pkg::ST_OUT: begin
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = grs_pkg::ST_IDLE;
                end
            end
            default: n_state = grs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= grs_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: sv/grs_dp.sv
// Sample store, age counters, gate logic and shared multiplier datapath.
module grs_dp #(
    parameter int AGE_BITS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  grs_pkg::t_dp_cmd                    i_cmd,
    input  grs_pkg::t_cfg                       i_cfg,
    input  logic signed [SAMPLE_BITS-1:0]       i_yaw_value,
    input  logic signed [SAMPLE_BITS-1:0]       i_pitch_value,
    input  logic                                i_angular_units,
    input  logic [3:0]                          i_meas_flags,
    input  logic [3:0]                          i_state_flags,
    output logic                                o_rate_mode,
    output logic signed [grs_pkg::RATE_W-1:0]   o_yaw_rate,
    output logic signed [grs_pkg::RATE_W-1:0]   o_pitch_rate,
    output logic [1:0]                          o_reason
);

    localparam int MA = (SAMPLE_BITS > grs_pkg::SAT_BIT) ? SAMPLE_BITS : grs_pkg::SAT_BIT;
    localparam int FW = grs_pkg::FACT_W;
    localparam int PW = MA + FW;
    localparam int QW = PW - grs_pkg::ROUND_BIT + 1;
    localparam int CW = (AGE_BITS > 16) ? AGE_BITS : 16;
    localparam int LW = grs_pkg::LIMIT_W;
    localparam int RW = grs_pkg::RATE_W;

    // sample store
    logic                    r_have_err, r_have_state;
    logic [AGE_BITS-1:0]     r_err_age, r_state_age;
    logic [SAMPLE_BITS-1:0]  r_yaw, r_pitch;
    logic                    r_ang;
    logic [3:0]              r_mflags, r_sflags;

    // update work registers
    logic                    r_mode;
    grs_pkg::t_reason        r_reason;
    logic                    r_neg_y, r_neg_p;
    logic [SAMPLE_BITS-1:0]  r_mag_y, r_mag_p;
    logic [FW-1:0]           r_fact_y, r_fact_p;
    logic [PW-1:0]           r_prod;
    logic                    r_sat;
    logic [RW-1:0]           r_yaw_res, r_pitch_res;

    // output payload
    logic                    r_o_mode;
    logic [RW-1:0]           r_o_yaw, r_o_pitch;
    grs_pkg::t_reason        r_o_reason;

    logic [15:0]             w_eff_sto, w_eff_eto;
    logic                    w_state_ok, w_err_ok;
    logic [MA-1:0]           w_mul_a;
    logic [FW-1:0]           w_mul_b;
    logic [QW-1:0]           w_q;
    logic [LW-1:0]           w_lim;
    logic                    w_neg;
    logic [LW-1:0]           w_q_clamped;
    logic [RW-1:0]           w_res;

    assign o_rate_mode  = r_o_mode;
    assign o_yaw_rate   = r_o_yaw;
    assign o_pitch_rate = r_o_pitch;
    assign o_reason     = r_o_reason;

    // freshness and flag checks
    always_comb begin
        w_eff_sto = (i_cfg.state_to < grs_pkg::MIN_TIMEOUT) ? grs_pkg::MIN_TIMEOUT
                                                             : i_cfg.state_to;
        w_eff_eto = (i_cfg.error_to < grs_pkg::MIN_TIMEOUT) ? grs_pkg::MIN_TIMEOUT
                                                             : i_cfg.error_to;
        w_state_ok = r_have_state && (CW'(r_state_age) <= CW'(w_eff_sto)) &&
                     (r_sflags[1:0] == 2'b11) && (r_sflags[3:2] == 2'b00);
        w_err_ok = r_have_err && (CW'(r_err_age) <= CW'(w_eff_eto)) &&
                   (r_mflags[1:0] == 2'b11) && !r_mflags[2] &&
                   (!i_cfg.req_ready || r_mflags[3]);
    end

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_op)
            grs_pkg::MUL_YAW_GAIN: begin
                w_mul_a = MA'(r_mag_y);
                w_mul_b = FW'(i_cfg.yaw_gain);
            end
            grs_pkg::MUL_YAW_FACT: begin
                w_mul_a = MA'(r_prod[grs_pkg::SAT_BIT-1:0]);
                w_mul_b = r_fact_y;
            end
            grs_pkg::MUL_PIT_GAIN: begin
                w_mul_a = MA'(r_mag_p);
                w_mul_b = FW'(i_cfg.pitch_gain);
            end
            grs_pkg::MUL_PIT_FACT: begin
                w_mul_a = MA'(r_prod[grs_pkg::SAT_BIT-1:0]);
                w_mul_b = r_fact_p;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // round to Q8.8, clamp, apply sign
    always_comb begin
        w_lim = i_cmd.fin_pitch ? i_cfg.max_pitch : i_cfg.max_yaw;
        w_neg = i_cmd.fin_pitch ? r_neg_p : r_neg_y;
        w_q = QW'(r_prod[PW-1:grs_pkg::ROUND_BIT]) + QW'(r_prod[grs_pkg::ROUND_BIT-1]);
        if (r_sat || (w_q > QW'(w_lim))) begin
            w_q_clamped = w_lim;
        end else begin
            w_q_clamped = w_q[LW-1:0];
        end
        w_res = w_neg ? (RW'(0) - RW'(w_q_clamped)) : RW'(w_q_clamped);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_err   <= 1'b0;
            r_have_state <= 1'b0;
            r_err_age    <= '0;
            r_state_age  <= '0;
        end else begin
            if (i_cmd.store_err) begin
                r_have_err <= 1'b1;
                r_err_age  <= '0;
            end else if (i_cmd.tick && (r_err_age != '1)) begin
                r_err_age <= r_err_age + AGE_BITS'(1);
            end
            if (i_cmd.store_state) begin
                r_have_state <= 1'b1;
                r_state_age  <= '0;
            end else if (i_cmd.tick && (r_state_age != '1)) begin
                r_state_age <= r_state_age + AGE_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_err) begin
            r_yaw    <= i_yaw_value;
            r_pitch  <= i_pitch_value;
            r_ang    <= i_angular_units;
            r_mflags <= i_meas_flags;
        end
        if (i_cmd.store_state) begin
            r_sflags <= i_state_flags;
        end
        if (i_cmd.start_upd) begin
            r_mode   <= i_cfg.track_en && w_state_ok && w_err_ok;
            r_reason <= !i_cfg.track_en ? grs_pkg::RSN_DISABLED :
                        !w_state_ok     ? grs_pkg::RSN_STATE    :
                        !w_err_ok       ? grs_pkg::RSN_MEAS     : grs_pkg::RSN_TRACK;
            r_neg_y  <= r_yaw[SAMPLE_BITS-1];
            r_neg_p  <= r_pitch[SAMPLE_BITS-1];
            // most negative code maps to its own bit pattern, read unsigned
            r_mag_y  <= r_yaw[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - r_yaw) : r_yaw;
            r_mag_p  <= r_pitch[SAMPLE_BITS-1] ? (SAMPLE_BITS'(0) - r_pitch) : r_pitch;
            r_fact_y <= r_ang ? grs_pkg::K_RAD : grs_pkg::K_YAW_NORM;
            r_fact_p <= r_ang ? grs_pkg::K_RAD : grs_pkg::K_PITCH_NORM;
        end
        if (i_cmd.mul_op != grs_pkg::MUL_NONE) begin
            r_prod <= PW'(w_mul_a) * PW'(w_mul_b);
        end
        if ((i_cmd.mul_op == grs_pkg::MUL_YAW_FACT) ||
            (i_cmd.mul_op == grs_pkg::MUL_PIT_FACT)) begin
            r_sat <= |r_prod[PW-1:grs_pkg::SAT_BIT];
        end
        if (i_cmd.fin_yaw) begin
            r_yaw_res <= w_res;
        end
        if (i_cmd.fin_pitch) begin
            r_pitch_res <= w_res;
        end
        if (i_cmd.load_out) begin
            r_o_mode   <= r_mode;
            r_o_yaw    <= r_mode ? r_yaw_res : '0;
            r_o_pitch  <= r_mode ? r_pitch_res : '0;
            r_o_reason <= r_reason;
        end
    end

endmodule

FILE: sv/gimbal_rate_servo_with_freshness_gate_core.sv
// Top level of the gimbal rate servo with sample freshness gate.
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  --------------------------------------
//  in        slave      i_in_valid / o_in_stall      i_kind, i_yaw_value, i_pitch_value,
//                                                    i_angular_units, i_meas_flags,
//                                                    i_state_flags
//  out       master     o_out_valid / i_out_stall    o_rate_mode, o_yaw_rate, o_pitch_rate,
//                                                    o_reason
//  cfg       slave      i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// Samples and ticks are taken at a rate of a transfer every cycle when idle.
// An update holds o_in_stall high through four products on the single shared
// multiplier (gain then degree factor, yaw then pitch), the final rounding, then
// the load into the output register, which waits while a prior result is stalled.
// Result valid is registered with that load, once the output slot is free.
// i_rst_n is synchronous, active low: control and configuration registers go to defaults, both samples absent.
// o_cfg_ready is always high; the user must write configuration only while the block is idle (not enforced).
module gimbal_rate_servo_with_freshness_gate_core #(
    parameter int AGE_BITS    = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_kind,
    input  logic signed [SAMPLE_BITS-1:0]     i_yaw_value,
    input  logic signed [SAMPLE_BITS-1:0]     i_pitch_value,
    input  logic                              i_angular_units,
    input  logic [3:0]                        i_meas_flags,
    input  logic [3:0]                        i_state_flags,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_rate_mode,
    output logic signed [grs_pkg::RATE_W-1:0] o_yaw_rate,
    output logic signed [grs_pkg::RATE_W-1:0] o_pitch_rate,
    output logic [1:0]                        o_reason,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [2:0]                        i_cfg_index,
    input  logic [grs_pkg::CFG_DW-1:0]        i_cfg_data
);

    grs_pkg::t_cfg    w_cfg;
    grs_pkg::t_dp_cmd w_cmd;

    // register file: gains, limits, timeouts, enables
    grs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    // sequencer: decodes item kind, steps the multiplier, owns output valid
    grs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_kind      (i_kind),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // datapath: stored samples, age counters, gate, multiplier, output payload
    grs_dp #(
        .AGE_BITS    (AGE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg           (w_cfg),
        .i_yaw_value     (i_yaw_value),
        .i_pitch_value   (i_pitch_value),
        .i_angular_units (i_angular_units),
        .i_meas_flags    (i_meas_flags),
        .i_state_flags   (i_state_flags),
        .o_rate_mode     (o_rate_mode),
        .o_yaw_rate      (o_yaw_rate),
        .o_pitch_rate    (o_pitch_rate),
        .o_reason        (o_reason)
    );

`ifndef SYNTH
    logic w_upd_xfer;
    assign w_upd_xfer = i_in_valid && !o_in_stall &&
                        (i_kind == grs_pkg::KIND_UPDATE);

    // an update transfer blocks the input until its result is loaded
    a_upd_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_upd_xfer |=> o_in_stall)
        else $error("input not stalled after update transfer");

    // a fresh result appears exactly at the end of the multiplier sequence
    a_out_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_upd_xfer, 7))
        else $error("result valid rose without matching update");

    // hold results carry zero rates and a non-tracking reason
    a_hold_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_rate_mode) |->
            (o_yaw_rate == '0) && (o_pitch_rate == '0) &&
            (o_reason != grs_pkg::RSN_TRACK))
        else $error("hold result with nonzero rate or tracking reason");

    // rate results always report tracking
    a_rate_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rate_mode) |-> (o_reason == grs_pkg::RSN_TRACK))
        else $error("rate result with hold reason");
`endif

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the gimbal rate servo core: queued stimulus, predictor, checker.
`timescale 1ns / 100ps

module tb_top;

    // ------------------------------------------------------------------
    // Local types and constants
    // ------------------------------------------------------------------
    // what the driver does with the head of its pending queue
    typedef enum logic [1:0] {
        OP_ITEM  = 2'd0,    // offer one item on the input channel
        OP_CFG   = 2'd1,    // register write, issued only once the block is idle
        OP_DRAIN = 2'd2     // sender pause until every result has come back
    } t_drv_op;

    typedef struct {
        t_drv_op            op;
        grs_pkg::t_kind     kind;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic               ang;
        logic [3:0]         meas;
        logic [3:0]         sflags;
        grs_pkg::t_reg_idx  ridx;
        logic [15:0]        data;
        int                 gap;    // idle cycles after this item's transfer
    } t_stim;

    // one rate/hold command as it should leave the block
    typedef struct packed {
        logic               rate_mode;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] pitch_rate;
        grs_pkg::t_reason   reason;
    } t_cmd;

    // flag bit positions
    localparam int MF_VALID   = 0;
    localparam int MF_VISIBLE = 1;
    localparam int MF_EST     = 2;
    localparam int MF_READY   = 3;
    localparam int SF_CONN    = 0;
    localparam int SF_ATT     = 1;
    localparam int SF_LIMIT   = 2;
    localparam int SF_FAULT   = 3;

    localparam logic [3:0] MEAS_GOOD  = 4'b1011;   // valid, visible, ready
    localparam logic [3:0] STATE_GOOD = 4'b0011;   // connected, attitude valid

    localparam int SETTLE      = 12;    // idle cycles required before a register write
    localparam int N_ITEMS     = 1750;
    localparam int N_PHASES    = 8;
    localparam int HOLD_LEN    = 400;   // long receiver hold-off
    localparam int STALE_TICKS = 30;    // error sample sits exactly at its timeout

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports
    // ------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_kind          = '0;
    logic signed [15:0] i_yaw_value     = '0;
    logic signed [15:0] i_pitch_value   = '0;
    logic               i_angular_units = 1'b0;
    logic [3:0]         i_meas_flags    = '0;
    logic [3:0]         i_state_flags   = '0;

    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic               o_rate_mode;
    logic signed [15:0] o_yaw_rate;
    logic signed [15:0] o_pitch_rate;
    logic [1:0]         o_reason;

    logic               i_cfg_valid     = 1'b0;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index     = '0;
    logic [15:0]        i_cfg_data      = '0;

    always #5 i_clk = ~i_clk;

    gimbal_rate_servo_with_freshness_gate_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_yaw_value     (i_yaw_value),
        .i_pitch_value   (i_pitch_value),
        .i_angular_units (i_angular_units),
        .i_meas_flags    (i_meas_flags),
        .i_state_flags   (i_state_flags),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_rate_mode     (o_rate_mode),
        .o_yaw_rate      (o_yaw_rate),
        .o_pitch_rate    (o_pitch_rate),
        .o_reason        (o_reason),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Servo predictor: own copy of registers and stored samples
    // ------------------------------------------------------------------
    grs_pkg::t_cfg      srv_cfg;
    logic               have_err, have_st;
    logic [15:0]        err_age, st_age;
    logic signed [15:0] err_yaw, err_pitch;
    logic               err_ang;
    logic [3:0]         err_flags, st_flags;

    t_cmd  cmd_q[$];        // commands predicted but not yet seen on the output
    t_stim pending[$];      // items, writes and pauses still to be driven

    int n_in_xfer = 0;
    int n_upd     = 0;
    int n_res     = 0;
    int n_cfg     = 0;
    int n_fail    = 0;
    int n_reason[4] = '{0, 0, 0, 0};

    task automatic servo_reset();
        srv_cfg.track_en   = 1'b0;
        srv_cfg.req_ready  = 1'b1;
        srv_cfg.state_to   = 16'd150;
        srv_cfg.error_to   = 16'd200;
        srv_cfg.yaw_gain   = 16'd4915;
        srv_cfg.pitch_gain = 16'd4915;
        srv_cfg.max_yaw    = 15'd7680;
        srv_cfg.max_pitch  = 15'd6400;
        have_err  = 1'b0;
        have_st   = 1'b0;
        err_age   = '0;
        st_age    = '0;
        err_yaw   = '0;
        err_pitch = '0;
        err_ang   = 1'b0;
        err_flags = '0;
        st_flags  = '0;
    endtask

    task automatic cfg_take(grs_pkg::t_reg_idx idx, logic [15:0] d);
        case (idx)
            grs_pkg::REG_TRACK_EN:   srv_cfg.track_en   = d[0];
            grs_pkg::REG_REQ_READY:  srv_cfg.req_ready  = d[0];
            grs_pkg::REG_STATE_TO:   srv_cfg.state_to   = d;
            grs_pkg::REG_ERROR_TO:   srv_cfg.error_to   = d;
            grs_pkg::REG_YAW_GAIN:   srv_cfg.yaw_gain   = d;
            grs_pkg::REG_PITCH_GAIN: srv_cfg.pitch_gain = d;
            grs_pkg::REG_MAX_YAW:    srv_cfg.max_yaw    = d[14:0];
            grs_pkg::REG_MAX_PITCH:  srv_cfg.max_pitch  = d[14:0];
            default: ;
        endcase
    endtask

    // error (Q12) * gain (Q12) * degree factor (Q16) on the magnitude,
    // rounded half away from zero to Q8.8, clamped, sign restored.
    // At these widths the product stays below 2^53, so no 64-bit overflow.
    function automatic logic signed [15:0] axis_deg_rate(logic signed [15:0] v,
                                                         logic [21:0] fac,
                                                         logic [15:0] gain,
                                                         logic [14:0] lim);
        logic [15:0] mag;
        logic [63:0] prod;
        logic [63:0] q;
        mag  = v[15] ? (~v + 16'd1) : v;     // -32768 gives 0x8000, as wanted
        prod = 64'(mag) * 64'(gain) * 64'(fac);
        q    = (prod >> 32) + 64'(prod[31]);
        if (q > 64'(lim))
            q = 64'(lim);
        return v[15] ? -q[15:0] : q[15:0];
    endfunction

    // freshness and flag gate, then rate command or hold with a reason
    function automatic t_cmd servo_command();
        t_cmd        c;
        logic [15:0] sto, eto;
        logic        st_ok, er_ok;
        sto = (srv_cfg.state_to < grs_pkg::MIN_TIMEOUT) ? grs_pkg::MIN_TIMEOUT
                                                        : srv_cfg.state_to;
        eto = (srv_cfg.error_to < grs_pkg::MIN_TIMEOUT) ? grs_pkg::MIN_TIMEOUT
                                                        : srv_cfg.error_to;
        st_ok = have_st && (st_age <= sto) && st_flags[SF_CONN] && st_flags[SF_ATT] &&
                !st_flags[SF_LIMIT] && !st_flags[SF_FAULT];
        er_ok = have_err && (err_age <= eto) && err_flags[MF_VALID] &&
                err_flags[MF_VISIBLE] && !err_flags[MF_EST] &&
                (!srv_cfg.req_ready || err_flags[MF_READY]);
        c = '0;
        if (srv_cfg.track_en && st_ok && er_ok) begin
            c.rate_mode  = 1'b1;
            c.yaw_rate   = axis_deg_rate(err_yaw,
                                         err_ang ? grs_pkg::K_RAD : grs_pkg::K_YAW_NORM,
                                         srv_cfg.yaw_gain, srv_cfg.max_yaw);
            c.pitch_rate = axis_deg_rate(err_pitch,
                                         err_ang ? grs_pkg::K_RAD : grs_pkg::K_PITCH_NORM,
                                         srv_cfg.pitch_gain, srv_cfg.max_pitch);
            c.reason     = grs_pkg::RSN_TRACK;
        end else if (!srv_cfg.track_en) begin
            c.reason = grs_pkg::RSN_DISABLED;
        end else if (!st_ok) begin
            c.reason = grs_pkg::RSN_STATE;
        end else begin
            c.reason = grs_pkg::RSN_MEAS;
        end
        return c;
    endfunction

    // apply one transferred item to the predictor
    task automatic servo_take(t_stim s);
        t_cmd c;
        case (s.kind)
            grs_pkg::KIND_ERROR: begin
                err_yaw   = s.yaw;
                err_pitch = s.pitch;
                err_ang   = s.ang;
                err_flags = s.meas;
                err_age   = '0;
                have_err  = 1'b1;
            end
            grs_pkg::KIND_STATE: begin
                st_flags = s.sflags;
                st_age   = '0;
                have_st  = 1'b1;
            end
            grs_pkg::KIND_TICK: begin
                // both ages saturate at all ones
                if (err_age != 16'hFFFF) err_age = err_age + 16'd1;
                if (st_age != 16'hFFFF)  st_age  = st_age + 16'd1;
            end
            default: begin
                c = servo_command();
                cmd_q.push_back(c);
                n_upd++;
                n_reason[c.reason]++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Input-side driver: works through the pending queue
    // ------------------------------------------------------------------
    t_stim cur;
    int    gap_left = 0;
    int    idle_run = 0;

    always @(posedge i_clk) begin
        logic nv, ncv;
        if (!i_rst_n) begin
            servo_reset();
            gap_left        = 0;
            idle_run        = 0;
            i_in_valid      <= 1'b0;
            i_cfg_valid     <= 1'b0;
            i_kind          <= '0;
            i_yaw_value     <= '0;
            i_pitch_value   <= '0;
            i_angular_units <= 1'b0;
            i_meas_flags    <= '0;
            i_state_flags   <= '0;
            i_cfg_index     <= '0;
            i_cfg_data      <= '0;
        end else begin
            nv  = i_in_valid;
            ncv = i_cfg_valid;

            // completed transfers at this edge
            if (i_in_valid && !o_in_stall) begin
                servo_take(cur);
                n_in_xfer++;
                nv = 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_take(cur.ridx, cur.data);
                n_cfg++;
                ncv = 1'b0;
            end

            // quiet cycles with nothing owed by the block; a sample or tick
            // may still be settling inside, hence the SETTLE margin
            if (cmd_q.size() == 0 && !i_in_valid && !i_cfg_valid) begin
                if (idle_run < 1000) idle_run++;
            end else begin
                idle_run = 0;
            end

            // next action, only once the channel is free
            if (!nv && !ncv) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending.size() != 0) begin
                    case (pending[0].op)
                        OP_ITEM: begin
                            cur             = pending.pop_front();
                            i_kind          <= cur.kind;
                            i_yaw_value     <= cur.yaw;
                            i_pitch_value   <= cur.pitch;
                            i_angular_units <= cur.ang;
                            i_meas_flags    <= cur.meas;
                            i_state_flags   <= cur.sflags;
                            gap_left        = cur.gap;
                            nv              = 1'b1;
                        end
                        OP_CFG: begin
                            if (idle_run >= SETTLE) begin
                                cur         = pending.pop_front();
                                i_cfg_index <= cur.ridx;
                                i_cfg_data  <= cur.data;
                                ncv         = 1'b1;
                            end
                        end
                        default: begin
                            if (idle_run >= SETTLE)
                                void'(pending.pop_front());
                        end
                    endcase
                end
            end

            i_in_valid  <= nv;
            i_cfg_valid <= ncv;
        end
    end

    // ------------------------------------------------------------------
    // Output side: random back-pressure and result check
    // ------------------------------------------------------------------
    int   hold_left = 0;
    int   run_left  = 0;
    logic run_stall = 1'b0;

    always @(posedge i_clk) begin
        t_cmd want;
        int   r;
        logic ns;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_res++;
                if (cmd_q.size() == 0) begin
                    n_fail++;
                    $display("%0t: unexpected result mode=%0d yaw=%0d pitch=%0d reason=%0d",
                             $time, o_rate_mode, o_yaw_rate, o_pitch_rate, o_reason);
                end else begin
                    want = cmd_q.pop_front();
                    if (o_rate_mode !== want.rate_mode || o_yaw_rate !== want.yaw_rate ||
                        o_pitch_rate !== want.pitch_rate || o_reason !== want.reason) begin
                        n_fail++;
                        $display("%0t: result %0d mismatch, expected mode=%0d yaw=%0d %s",
                                 $time, n_res, want.rate_mode, want.yaw_rate,
                                 $sformatf("pitch=%0d reason=%0d", want.pitch_rate,
                                           want.reason));
                        $display("%0t:   actual mode=%0d yaw=%0d pitch=%0d reason=%0d",
                                 $time, o_rate_mode, o_yaw_rate, o_pitch_rate, o_reason);
                    end
                end
                // long hold-off twice, so the block backs up onto its input
                if (n_res == 40 || n_res == 200)
                    hold_left = HOLD_LEN;
            end

            if (hold_left != 0) begin
                hold_left--;
                ns = 1'b1;
            end else begin
                if (run_left == 0) begin
                    r = $urandom_range(0, 99);
                    if (r < 15) begin
                        run_stall = 1'b0; run_left = $urandom_range(40, 100);
                    end else if (r < 60) begin
                        run_stall = 1'b0; run_left = $urandom_range(1, 8);
                    end else if (r < 92) begin
                        run_stall = 1'b1; run_left = $urandom_range(1, 3);
                    end else begin
                        run_stall = 1'b1; run_left = $urandom_range(15, 40);
                    end
                end
                run_left--;
                ns = run_stall;
            end
            i_out_stall <= ns;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    int burst_left = 0;     // items still to go with no idle gap
    int n_queued   = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        int r;
        logic signed [15:0] v;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            case ($urandom_range(0, 4))
                0: v = 16'sh8000;
                1: v = -16'sd1;
                2: v = 16'sd0;
                3: v = 16'sd1;
                default: v = 16'sh7FFF;
            endcase
        end else if (r < 55) begin
            v = 16'($urandom_range(0, 4095));
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            v = 16'($urandom);
        end
        return v;
    endfunction

    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            case ($urandom_range(0, 3))
                0: return 16'd0;        // below the floor, acts as 20
                1: return 16'd19;
                2: return 16'd20;
                default: return 16'd21;
            endcase
        end
        if (r < 55) return 16'($urandom_range(20, 40));
        if (r < 65) return 16'hFFFF;
        return 16'($urandom_range(20, 300));
    endfunction

    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'd0;
        if (r < 20) return 16'hFFFF;
        if (r < 50) return 16'($urandom_range(2048, 8192));
        return 16'($urandom);
    endfunction

    function automatic logic [14:0] pick_limit();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 15'd0;
        if (r < 20) return 15'h7FFF;
        return 15'($urandom);
    endfunction

    task automatic add_item(grs_pkg::t_kind k, logic signed [15:0] y, logic signed [15:0] p,
                            logic a, logic [3:0] m, logic [3:0] s);
        t_stim e;
        e.op     = OP_ITEM;
        e.kind   = k;
        e.yaw    = y;
        e.pitch  = p;
        e.ang    = a;
        e.meas   = m;
        e.sflags = s;
        e.ridx   = grs_pkg::REG_TRACK_EN;
        e.data   = '0;
        if (burst_left > 0) begin
            e.gap = 0;
            burst_left--;
        end else begin
            e.gap = pick_gap();
        end
        pending.push_back(e);
        n_queued++;
    endtask

    // update request with junk payload, which the block must ignore
    task automatic add_update();
        add_item(grs_pkg::KIND_UPDATE, 16'($urandom), 16'($urandom), 1'($urandom),
                 4'($urandom), 4'($urandom));
    endtask

    task automatic add_tick();
        add_item(grs_pkg::KIND_TICK, 16'($urandom), 16'($urandom), 1'($urandom),
                 4'($urandom), 4'($urandom));
    endtask

    task automatic add_cfg(grs_pkg::t_reg_idx idx, logic [15:0] d);
        t_stim e;
        e = '{op: OP_CFG, kind: grs_pkg::KIND_TICK, yaw: '0, pitch: '0, ang: 1'b0,
              meas: '0, sflags: '0, ridx: idx, data: d, gap: 0};
        pending.push_back(e);
    endtask

    task automatic add_drain();
        t_stim e;
        e = '{op: OP_DRAIN, kind: grs_pkg::KIND_TICK, yaw: '0, pitch: '0, ang: 1'b0,
              meas: '0, sflags: '0, ridx: grs_pkg::REG_TRACK_EN, data: '0, gap: 0};
        pending.push_back(e);
    endtask

    // write every register; unused upper data bits get random values
    task automatic add_cfg_set(grs_pkg::t_cfg c);
        add_cfg(grs_pkg::REG_TRACK_EN,   {15'($urandom), c.track_en});
        add_cfg(grs_pkg::REG_REQ_READY,  {15'($urandom), c.req_ready});
        add_cfg(grs_pkg::REG_STATE_TO,   c.state_to);
        add_cfg(grs_pkg::REG_ERROR_TO,   c.error_to);
        add_cfg(grs_pkg::REG_YAW_GAIN,   c.yaw_gain);
        add_cfg(grs_pkg::REG_PITCH_GAIN, c.pitch_gain);
        add_cfg(grs_pkg::REG_MAX_YAW,    {1'($urandom), c.max_yaw});
        add_cfg(grs_pkg::REG_MAX_PITCH,  {1'($urandom), c.max_pitch});
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        grs_pkg::t_cfg c;
        int            p, j, r, nt, nu, skip, phase_end, guard;
        logic          order;
        logic          drained;
        logic [3:0]    m, s;

        // --- directed part, starting from reset register values ---
        add_update();                                           // disabled at reset
        add_cfg(grs_pkg::REG_TRACK_EN, 16'hFFFF);
        add_update();                                           // no samples at all
        add_item(grs_pkg::KIND_ERROR, 16'sh7FFF, 16'sh8000, 1'b1, MEAS_GOOD, 4'hF);
        add_update();                                           // state still missing
        add_item(grs_pkg::KIND_STATE, 16'sh1234, -16'sd77, 1'b0, 4'h0, STATE_GOOD);
        add_update();                                           // both axes clamp
        add_item(grs_pkg::KIND_ERROR, 16'sd1, -16'sd1, 1'b0, MEAS_GOOD, 4'h0);
        add_update();                                           // tiny normalized rates
        add_item(grs_pkg::KIND_ERROR, 16'sd0, 16'sd0, 1'b1, 4'b1111, 4'h0);
        add_update();                                           // estimated
        add_item(grs_pkg::KIND_ERROR, 16'sd100, 16'sd100, 1'b1, 4'b0011, 4'h0);
        add_update();                                           // not ready
        add_item(grs_pkg::KIND_ERROR, 16'sd100, 16'sd100, 1'b1, 4'b1001, 4'h0);
        add_update();                                           // not visible
        add_item(grs_pkg::KIND_ERROR, 16'sd100, 16'sd100, 1'b1, 4'b1010, 4'h0);
        add_update();                                           // not valid
        add_item(grs_pkg::KIND_ERROR, -16'sd1234, 16'sd777, 1'b0, MEAS_GOOD, 4'h0);
        add_item(grs_pkg::KIND_STATE, 16'sd0, 16'sd0, 1'b0, 4'h0, 4'b0111);
        add_update();                                           // limit active
        add_item(grs_pkg::KIND_STATE, 16'sd0, 16'sd0, 1'b0, 4'h0, 4'b1011);
        add_update();                                           // fault
        add_item(grs_pkg::KIND_STATE, 16'sd0, 16'sd0, 1'b0, 4'h0, 4'b0001);
        add_update();                                           // attitude invalid
        add_item(grs_pkg::KIND_STATE, 16'sd0, 16'sd0, 1'b0, 4'h0, 4'b0010);
        add_item(grs_pkg::KIND_ERROR, 16'sd0, 16'sd0, 1'b0, 4'b0000, 4'h0);
        add_update();                                           // both bad: state wins
        add_cfg(grs_pkg::REG_TRACK_EN, 16'hFFFE);
        add_update();                                           // disabled beats all

        // --- random phases, each under its own register setting ---
        for (p = 0; p < N_PHASES; p++) begin
            c.track_en   = 1'b1;
            c.req_ready  = 1'($urandom_range(0, 1));
            c.state_to   = pick_timeout();
            c.error_to   = pick_timeout();
            c.yaw_gain   = pick_gain();
            c.pitch_gain = pick_gain();
            c.max_yaw    = pick_limit();
            c.max_pitch  = pick_limit();
            case (p)
                0: begin c.req_ready = 1'b0; c.state_to = 16'd0; c.error_to = 16'd19; end
                1: begin
                    c.yaw_gain = 16'hFFFF; c.pitch_gain = 16'hFFFF;
                    c.max_yaw  = 15'h7FFF; c.max_pitch  = 15'h7FFF;
                    c.state_to = 16'd20;   c.error_to   = 16'd21;
                end
                2: begin c.yaw_gain = 16'd0; c.pitch_gain = 16'd0; end
                3: begin c.max_yaw = 15'd0; c.max_pitch = 15'd0; end
                4: c.track_en = 1'b0;
                5: begin
                    c.yaw_gain = 16'd4915; c.pitch_gain = 16'd4915;
                    c.max_yaw  = 15'd7680; c.max_pitch  = 15'd6400;
                end
                default: ;
            endcase
            add_cfg_set(c);

            drained   = 1'b0;
            phase_end = n_queued + (N_ITEMS - n_queued) / (N_PHASES - p);
            while (n_queued < phase_end) begin
                if ($urandom_range(0, 19) == 0)
                    burst_left = 40;
                // sender pause half way through two phases
                if ((p == 2 || p == 5) && !drained && n_queued >= phase_end - 100) begin
                    add_drain();
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 72) begin
                    // well-formed: samples (one may be skipped), ticks, updates
                    order = 1'($urandom_range(0, 1));
                    skip  = $urandom_range(0, 9);
                    for (j = 0; j < 2; j++) begin
                        if ((j[0] ^ order) == 1'b0 && skip != 0) begin
                            m = MEAS_GOOD;
                            if (!c.req_ready && $urandom_range(0, 1) == 1)
                                m[MF_READY] = 1'b0;
                            if ($urandom_range(0, 99) < 15)
                                m = 4'($urandom);
                            add_item(grs_pkg::KIND_ERROR, pick_sample(), pick_sample(),
                                     1'($urandom), m, 4'($urandom));
                        end
                        if ((j[0] ^ order) == 1'b1 && skip != 1) begin
                            s = ($urandom_range(0, 99) < 15) ? 4'($urandom) : STATE_GOOD;
                            add_item(grs_pkg::KIND_STATE, 16'($urandom), 16'($urandom),
                                     1'($urandom), 4'($urandom), s);
                        end
                    end
                    // mostly a few ticks, sometimes right around the 20 tick floor
                    nt = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 5)
                                                    : $urandom_range(17, 24);
                    repeat (nt) add_tick();
                    nu = $urandom_range(1, 3);
                    repeat (nu) begin
                        add_update();
                        if ($urandom_range(0, 3) == 0)
                            add_tick();
                    end
                end else begin
                    // noise: any kind, any payload
                    repeat ($urandom_range(1, 4))
                        add_item(grs_pkg::t_kind'($urandom_range(0, 3)), 16'($urandom),
                                 16'($urandom), 1'($urandom), 4'($urandom), 4'($urandom));
                end
            end
        end

        // --- staleness at the exact timeout edge, error first, then state ---
        c = '{track_en: 1'b1, req_ready: 1'b0, state_to: 16'd40, error_to: 16'd30,
              yaw_gain: 16'd4915, pitch_gain: 16'd4915, max_yaw: 15'd7680,
              max_pitch: 15'd6400};
        add_cfg_set(c);
        add_item(grs_pkg::KIND_ERROR, 16'sd500, -16'sd500, 1'b1, MEAS_GOOD, 4'h0);
        add_item(grs_pkg::KIND_STATE, 16'sd0, 16'sd0, 1'b0, 4'h0, STATE_GOOD);
        burst_left = STALE_TICKS + 1;
        repeat (STALE_TICKS) add_tick();
        add_update();                                           // error age at its limit
        add_tick();
        add_update();                                           // error one tick stale
        repeat (10) add_tick();
        add_update();                                           // both stale
        add_cfg(grs_pkg::REG_STATE_TO, 16'hFFFF);
        add_update();                                           // state fresh, error stale
        add_cfg(grs_pkg::REG_ERROR_TO, 16'hFFFF);
        add_update();                                           // both fresh again

        // --- reset, then let the driver and checker run ---
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending.size() != 0 || i_in_valid || i_cfg_valid)
            @(posedge i_clk);
        guard = 0;
        while (cmd_q.size() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (cmd_q.size() != 0) begin
            n_fail++;
            $display("%0t: %0d expected results never arrived", $time, cmd_q.size());
        end

        $display("Covered %0d input transfers, %0d updates: %0d tracking, %0d disabled, %0d %s",
                 n_in_xfer, n_upd, n_reason[grs_pkg::RSN_TRACK],
                 n_reason[grs_pkg::RSN_DISABLED], n_reason[grs_pkg::RSN_STATE],
                 "gimbal-state holds");
        $display("%0d measurement holds, %0d results checked, %0d register writes, %0d mismatches",
                 n_reason[grs_pkg::RSN_MEAS], n_res, n_cfg, n_fail);
        if (n_fail == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #(20_000_000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/grs_pkg.sv
sv/grs_cfg.sv
sv/grs_ctrl.sv
sv/grs_dp.sv
sv/gimbal_rate_servo_with_freshness_gate_core.sv
tb/tb_top.sv
